FILE: design/bmr_pkg.sv
// ----------------------------------------------------------------------------
// bmr_pkg
// Shared constants and types for the block mean removal datapath.
// ----------------------------------------------------------------------------
package bmr_pkg;

  // width of the block length register
  localparam int unsigned LEN_W = 7;
  localparam logic [LEN_W-1:0] LEN_RESET = 7'd64;

  // defaults for the top level parameters
  localparam int unsigned MAX_BLOCK_DEF   = 64;
  localparam int unsigned SAMPLE_BITS_DEF = 16;

  // back end tells the front end that a buffer bank is free again
  typedef struct packed {
    logic valid;
    logic bank;
  } bmr_free_t;

endpackage

FILE: design/bmr_if.sv
// ----------------------------------------------------------------------------
// bmr interfaces
// Valid/ready channels for input samples and centered results.
// ----------------------------------------------------------------------------
interface bmr_sample_if #(
  parameter int unsigned W = 16
) ();
  logic         valid;
  logic         ready;
  logic [W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface bmr_result_if #(
  parameter int unsigned W = 17
) ();
  logic         valid;
  logic         ready;
  logic [W-1:0] centered;
  logic         last_of_block;

  modport source (output valid, output centered, output last_of_block, input ready);
  modport sink (input valid, input centered, input last_of_block, output ready);
endinterface

FILE: design/bmr_front.sv
// ----------------------------------------------------------------------------
// bmr_front
// Accepts samples, writes them to the current bank, keeps the running sum
// and hands a finished block (bank, sum, count) to the job queue.
// ----------------------------------------------------------------------------
module bmr_front
  import bmr_pkg::*;
#(
  parameter int unsigned MAX_BLOCK   = MAX_BLOCK_DEF,
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int unsigned CNT_W       = $clog2(MAX_BLOCK + 1),
  parameter int unsigned AW          = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1,
  parameter int unsigned SUM_W       = SAMPLE_BITS + CNT_W,
  parameter int unsigned JOB_W       = 1 + CNT_W + SUM_W
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [LEN_W-1:0]       cfg_data_i,
  bmr_sample_if.sink             samples_i,
  output logic                   mem_we_o,
  output logic [AW:0]            mem_addr_o,
  output logic [SAMPLE_BITS-1:0] mem_data_o,
  output logic                   job_push_o,
  output logic [JOB_W-1:0]       job_data_o,
  input  bmr_free_t              free_i
);

  logic [LEN_W-1:0] block_length_q;
  logic [CNT_W-1:0] fill_q, fill_d;
  logic [SUM_W-1:0] sum_q, sum_d;
  logic             bank_q, bank_d;
  logic [1:0]       busy_q, busy_d;

  logic [LEN_W-1:0] eff_len;
  logic [CNT_W-1:0] fill_inc;
  logic [SUM_W-1:0] sum_new;
  logic             accept;
  logic             complete;

  always_comb begin
    if (block_length_q == '0) begin
      eff_len = LEN_W'(1);
    end else if (block_length_q > LEN_W'(MAX_BLOCK)) begin
      eff_len = LEN_W'(MAX_BLOCK);
    end else begin
      eff_len = block_length_q;
    end
  end

  assign samples_i.ready = !busy_q[bank_q];
  assign accept          = samples_i.valid && samples_i.ready;
  assign fill_inc        = fill_q + CNT_W'(1);
  assign sum_new         = sum_q + {{(SUM_W-SAMPLE_BITS){samples_i.sample[SAMPLE_BITS-1]}},
                                    samples_i.sample};
  assign complete        = LEN_W'(fill_inc) >= eff_len;

  assign mem_we_o   = accept;
  assign mem_addr_o = {bank_q, fill_q[AW-1:0]};
  assign mem_data_o = samples_i.sample;

  assign job_push_o = accept && complete;
  assign job_data_o = {bank_q, fill_inc, sum_new};

  always_comb begin
    fill_d = fill_q;
    sum_d  = sum_q;
    bank_d = bank_q;
    busy_d = busy_q;
    if (free_i.valid) begin
      busy_d[free_i.bank] = 1'b0;
    end
    if (accept) begin
      if (complete) begin
        fill_d         = '0;
        sum_d          = '0;
        bank_d         = !bank_q;
        busy_d[bank_q] = 1'b1;
      end else begin
        fill_d = fill_inc;
        sum_d  = sum_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_length_q <= LEN_RESET;
      fill_q         <= '0;
      sum_q          <= '0;
      bank_q         <= 1'b0;
      busy_q         <= '0;
    end else begin
      if (cfg_we_i) begin
        block_length_q <= cfg_data_i;
      end
      fill_q <= fill_d;
      sum_q  <= sum_d;
      bank_q <= bank_d;
      busy_q <= busy_d;
    end
  end

  // the bank being filled is never the one the back end is draining
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_i.valid |-> (free_i.bank != bank_q) || !busy_q[bank_q] || busy_q[!bank_q])
    else $error("bank freed while front end still filling it");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> LEN_W'(fill_q) < LEN_W'(MAX_BLOCK))
    else $error("fill count ran past the block size");

endmodule

FILE: design/bmr_job_fifo.sv
// ----------------------------------------------------------------------------
// bmr_job_fifo
// Two-entry queue of finished blocks between the front and back ends.
// ----------------------------------------------------------------------------
module bmr_job_fifo
  import bmr_pkg::*;
#(
  parameter int unsigned JOB_W = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [JOB_W-1:0] push_data_i,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [JOB_W-1:0] data_o
);

  logic [JOB_W-1:0] entry_q [2];
  logic             wptr_q, rptr_q;
  logic [1:0]       count_q;

  assign valid_o = count_q != 2'd0;
  assign data_o  = entry_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= !wptr_q;
      end
      if (pop_i) begin
        rptr_q <= !rptr_q;
      end
      count_q <= count_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (count_q != 2'd2) || pop_i)
    else $error("job queue overflow");

endmodule

FILE: design/bmr_back.sv
// ----------------------------------------------------------------------------
// bmr_back
// Divides the block sum by the sample count, one quotient bit a cycle, then
// reads the bank back and emits each sample minus the mean.
// ----------------------------------------------------------------------------
module bmr_back
  import bmr_pkg::*;
#(
  parameter int unsigned MAX_BLOCK   = MAX_BLOCK_DEF,
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int unsigned CNT_W       = $clog2(MAX_BLOCK + 1),
  parameter int unsigned AW          = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1,
  parameter int unsigned SUM_W       = SAMPLE_BITS + CNT_W,
  parameter int unsigned JOB_W       = 1 + CNT_W + SUM_W
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   mem_we_i,
  input  logic [AW:0]            mem_addr_i,
  input  logic [SAMPLE_BITS-1:0] mem_data_i,
  input  logic                   job_valid_i,
  input  logic [JOB_W-1:0]       job_data_i,
  output logic                   job_pop_o,
  bmr_result_if.source           results_o,
  output bmr_free_t              free_o
);

  localparam int unsigned STEP_W = $clog2(SUM_W);
  localparam int unsigned OUT_W  = SAMPLE_BITS + 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [SAMPLE_BITS-1:0] mem [2**(AW+1)];
  logic [SAMPLE_BITS-1:0] rd_data_q;

  logic [1:0]        state_q, state_d;
  logic              bank_q, bank_d;
  logic [CNT_W-1:0]  n_q, n_d;
  logic [CNT_W-1:0]  k_q, k_d;
  logic [CNT_W-1:0]  rem_q, rem_d;
  logic [SUM_W-1:0]  dvd_q, dvd_d;
  logic              neg_q, neg_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [OUT_W-1:0]  mean_q, mean_d;

  logic              out_valid_q, out_valid_d;
  logic [OUT_W-1:0]  centered_q, centered_d;
  logic              last_q, last_d;

  logic              job_bank;
  logic [CNT_W-1:0]  job_n;
  logic [SUM_W-1:0]  job_sum;
  logic [CNT_W:0]    rem_sh;
  logic              ge;
  logic [SUM_W-1:0]  quot;
  logic              is_last;
  logic              load_out;

  assign {job_bank, job_n, job_sum} = job_data_i;

  // restoring division step on the magnitude
  assign rem_sh  = {rem_q, dvd_q[SUM_W-1]};
  assign ge      = rem_sh >= {1'b0, n_q};
  assign quot    = {dvd_q[SUM_W-2:0], ge};
  assign is_last = k_q == (n_q - CNT_W'(1));
  assign load_out = (state_q == ST_EMIT) && (!out_valid_q || results_o.ready);

  assign job_pop_o = (state_q == ST_IDLE) && job_valid_i;

  always_comb begin
    state_d     = state_q;
    bank_d      = bank_q;
    n_d         = n_q;
    k_d         = k_q;
    rem_d       = rem_q;
    dvd_d       = dvd_q;
    neg_d       = neg_q;
    step_d      = step_q;
    mean_d      = mean_q;
    out_valid_d = out_valid_q && !results_o.ready;
    centered_d  = centered_q;
    last_d      = last_q;
    free_o      = '0;
    case (state_q)
      ST_IDLE: begin
        k_d = '0;
        if (job_valid_i) begin
          bank_d  = job_bank;
          n_d     = job_n;
          neg_d   = job_sum[SUM_W-1];
          dvd_d   = job_sum[SUM_W-1] ? -job_sum : job_sum;
          rem_d   = '0;
          step_d  = STEP_W'(SUM_W - 1);
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        rem_d  = ge ? CNT_W'(rem_sh - {1'b0, n_q}) : rem_sh[CNT_W-1:0];
        dvd_d  = quot;
        step_d = step_q - STEP_W'(1);
        if (step_q == '0) begin
          // truncation toward zero: negate the magnitude quotient
          mean_d  = neg_q ? OUT_W'(-quot) : quot[OUT_W-1:0];
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (load_out) begin
          out_valid_d = 1'b1;
          centered_d  = {rd_data_q[SAMPLE_BITS-1], rd_data_q} - mean_q;
          last_d      = is_last;
          k_d         = k_q + CNT_W'(1);
          if (is_last) begin
            free_o.valid = 1'b1;
            free_o.bank  = bank_q;
            state_d      = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // read address follows the next index so data lines up with k_q
  always_ff @(posedge clk_i) begin
    if (mem_we_i) begin
      mem[mem_addr_i] <= mem_data_i;
    end
    rd_data_q <= mem[{bank_d, k_d[AW-1:0]}];
  end

  always_ff @(posedge clk_i) begin
    n_q        <= n_d;
    k_q        <= k_d;
    rem_q      <= rem_d;
    dvd_q      <= dvd_d;
    neg_q      <= neg_d;
    step_q     <= step_d;
    mean_q     <= mean_d;
    centered_q <= centered_d;
    last_q     <= last_d;
    bank_q     <= bank_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign results_o.valid         = out_valid_q;
  assign results_o.centered      = centered_q;
  assign results_o.last_of_block = last_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> (k_q < n_q))
    else $error("emit index past block count");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (n_q != '0))
    else $error("division by a zero sample count");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_o.valid |=> (state_q == ST_IDLE) && out_valid_q && results_o.last_of_block)
    else $error("bank released without the final result in the output register");

endmodule

FILE: design/block_mean_removal.sv
// ----------------------------------------------------------------------------
// block_mean_removal
// The first result of a block is valid after its last accepted sample has
// passed through the job queue, the serial divider (one step per sum bit,
// SAMPLE_BITS + 7 = 23 by default) and the output register; the other results
// follow one per cycle while the receiver is ready. Throughput: a sample per
// cycle on the input while a bank is free, a result per cycle on the output
// while the receiver is ready; the two sample banks let the next block load
// while the previous one drains. Reset clears counts, sum and queues.
// ----------------------------------------------------------------------------
module block_mean_removal
  import bmr_pkg::*;
#(
  parameter int unsigned MAX_BLOCK   = MAX_BLOCK_DEF,
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [LEN_W-1:0] cfg_data_i,
  bmr_sample_if.sink       samples_i,
  bmr_result_if.source     results_o
);

  localparam int unsigned CNT_W = $clog2(MAX_BLOCK + 1);
  localparam int unsigned AW    = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;
  localparam int unsigned SUM_W = SAMPLE_BITS + CNT_W;
  localparam int unsigned JOB_W = 1 + CNT_W + SUM_W;

  logic                   mem_we;
  logic [AW:0]            mem_addr;
  logic [SAMPLE_BITS-1:0] mem_data;
  logic                   job_push;
  logic [JOB_W-1:0]       job_push_data;
  logic                   job_valid;
  logic [JOB_W-1:0]       job_data;
  logic                   job_pop;
  bmr_free_t              free;

  bmr_front #(
    .MAX_BLOCK  (MAX_BLOCK),
    .SAMPLE_BITS(SAMPLE_BITS),
    .CNT_W      (CNT_W),
    .AW         (AW),
    .SUM_W      (SUM_W),
    .JOB_W      (JOB_W)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_data_i(cfg_data_i),
    .samples_i (samples_i),
    .mem_we_o  (mem_we),
    .mem_addr_o(mem_addr),
    .mem_data_o(mem_data),
    .job_push_o(job_push),
    .job_data_o(job_push_data),
    .free_i    (free)
  );

  bmr_job_fifo #(
    .JOB_W(JOB_W)
  ) u_job_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (job_push),
    .push_data_i(job_push_data),
    .pop_i      (job_pop),
    .valid_o    (job_valid),
    .data_o     (job_data)
  );

  bmr_back #(
    .MAX_BLOCK  (MAX_BLOCK),
    .SAMPLE_BITS(SAMPLE_BITS),
    .CNT_W      (CNT_W),
    .AW         (AW),
    .SUM_W      (SUM_W),
    .JOB_W      (JOB_W)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .mem_we_i   (mem_we),
    .mem_addr_i (mem_addr),
    .mem_data_i (mem_data),
    .job_valid_i(job_valid),
    .job_data_i (job_data),
    .job_pop_o  (job_pop),
    .results_o  (results_o),
    .free_o     (free)
  );

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for block_mean_removal. Samples are queued by the
// stimulus block and fed to the sample channel by a clocked driver. Every
// accepted sample also updates a local block model that queues the centered
// values it predicts. A clocked monitor compares each result transaction
// with the oldest prediction. Block length changes only while the design
// is idle, and some of those changes land mid-block.
// ----------------------------------------------------------------------------
module tb_top;
  import bmr_pkg::*;

  localparam int unsigned MAXB        = MAX_BLOCK_DEF;
  localparam int unsigned SW          = SAMPLE_BITS_DEF;
  localparam int unsigned SETTLE      = 60;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned PHASE_ITEMS = 65;

  typedef struct packed {
    logic signed [SW:0] centered;
    logic               last;
  } centered_t;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             cfg_we;
  logic [LEN_W-1:0] cfg_data;

  bmr_sample_if #(.W(SW))   smp_if ();
  bmr_result_if #(.W(SW+1)) res_if ();

  block_mean_removal dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we),
    .cfg_data_i(cfg_data),
    .samples_i (smp_if),
    .results_o (res_if)
  );

  always #10 clk_i = ~clk_i;

  // block model
  logic signed [SW-1:0] held [MAXB];
  logic signed [SW+5:0] held_sum;
  int unsigned          held_count;
  logic [LEN_W-1:0]     len_setting;

  logic [SW-1:0] sample_backlog [$];
  centered_t     centered_due [$];

  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;
  int unsigned send_gap_pct = 0;
  int unsigned stall_pct = 0;
  logic        long_hold_go = 1'b0;
  logic        long_hold_done = 1'b0;

  function automatic int unsigned eff_len(logic [LEN_W-1:0] len);
    if (len == 0) begin
      return 1;
    end else if (len > MAXB) begin
      return MAXB;
    end
    return len;
  endfunction

  function automatic void fold_in_sample(logic signed [SW-1:0] s);
    logic signed [SW+5:0] n_signed;
    logic signed [SW+5:0] mean;
    centered_t            c;
    if (held_count < MAXB) begin
      held[held_count] = s;
      held_sum += s;
      held_count++;
    end
    if (held_count >= eff_len(len_setting)) begin
      n_signed = (SW+6)'(held_count);
      mean = held_sum / n_signed;
      for (int k = 0; k < held_count; k++) begin
        c.centered = (SW+1)'(held[k] - mean);
        c.last = (k + 1 == held_count);
        centered_due.push_back(c);
      end
      held_sum = '0;
      held_count = 0;
    end
  endfunction

  // sample driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      smp_if.valid <= 1'b0;
    end else begin
      if (smp_if.valid && smp_if.ready) begin
        fold_in_sample(smp_if.sample);
      end
      if (!smp_if.valid || smp_if.ready) begin
        if (sample_backlog.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          smp_if.valid <= 1'b1;
          smp_if.sample <= sample_backlog.pop_front();
        end else begin
          smp_if.valid <= 1'b0;
        end
      end
    end
  end

  // result ready, with an optional long hold-off
  always @(posedge clk_i) begin
    res_if.ready <= !(long_hold_go && !long_hold_done) && ($urandom_range(99) >= stall_pct);
  end

  initial begin
    wait (long_hold_go);
    repeat (HOLD_CYCLES) @(posedge clk_i);
    long_hold_done <= 1'b1;
  end

  // result monitor
  always @(posedge clk_i) begin
    centered_t exp_c;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (centered_due.size() == 0) begin
        $display("%0t unexpected result: expected none, actual centered=%0d last=%0b",
                 $time, $signed(res_if.centered), res_if.last_of_block);
        fail_count++;
      end else begin
        exp_c = centered_due.pop_front();
        if (res_if.centered !== exp_c.centered) begin
          $display("%0t centered mismatch: expected %0d, actual %0d",
                   $time, exp_c.centered, $signed(res_if.centered));
          fail_count++;
        end
        if (res_if.last_of_block !== exp_c.last) begin
          $display("%0t last_of_block mismatch: expected %0b, actual %0b",
                   $time, exp_c.last, res_if.last_of_block);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic write_block_length(input logic [LEN_W-1:0] v);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_data <= v;
    len_setting = v;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // all samples taken, all results seen, divider given time to finish
  task automatic drain();
    wait (sample_backlog.size() == 0 && !smp_if.valid);
    wait (centered_due.size() == 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  function automatic logic [SW-1:0] pick_sample();
    case ($urandom_range(7))
      0: return 16'h8000;
      1: return 16'h7fff;
      default: return SW'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [LEN_W-1:0] pick_length();
    case ($urandom_range(9))
      6: return '0;
      7: return LEN_W'(MAXB);
      8: return LEN_W'($urandom_range(MAXB + 1, 127));
      9: return LEN_W'($urandom_range(9, MAXB - 1));
      default: return LEN_W'($urandom_range(1, 8));
    endcase
  endfunction

  initial begin
    int unsigned in_phase;
    int unsigned k;
    int          need;
    smp_if.valid = 1'b0;
    smp_if.sample = '0;
    res_if.ready = 1'b0;
    cfg_we = 1'b0;
    cfg_data = '0;
    rst_ni = 1'b0;
    held_sum = '0;
    held_count = 0;
    len_setting = LEN_RESET;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // zero length acts as one: every sample is its own block
    write_block_length('0);
    sample_backlog = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff};
    drain();

    // pairs: extremes and truncation of a negative mean
    write_block_length(7'd2);
    sample_backlog = '{16'h7fff, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000,
                       16'h8001, 16'hfffd, 16'h0000, 16'h0003, 16'h0000};
    drain();

    // shrink to the current fill mid-block
    write_block_length(7'd3);
    sample_backlog.push_back(16'h5555);
    drain();
    write_block_length(7'd1);
    sample_backlog.push_back(16'haaaa);
    drain();

    // oversized length saturates, then shrinks mid-block
    write_block_length(7'd100);
    sample_backlog = '{16'h1234, 16'hedcb, 16'h7ffe};
    drain();
    write_block_length(7'd3);
    sample_backlog.push_back(16'h8001);
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_gap_pct = 0;  stall_pct = 0;  end
        1: begin send_gap_pct = 50; stall_pct = 0;  end
        2: begin send_gap_pct = 0;  stall_pct = 50; end
        default: begin send_gap_pct = 20; stall_pct = 20; end
      endcase
      in_phase = 0;
      while (in_phase < PHASE_ITEMS) begin
        write_block_length(pick_length());
        need = int'(eff_len(len_setting)) - int'(held_count);
        if (need < 1) begin
          need = 1;
        end
        if ($urandom_range(3) == 0) begin
          k = $urandom_range(1, 12);
        end else begin
          k = need + eff_len(len_setting) * $urandom_range(0, 2);
        end
        if (k > 70) begin
          k = 70;
        end
        for (int i = 0; i < k; i++) begin
          sample_backlog.push_back(pick_sample());
        end
        in_phase += k;
        drain();
      end
    end

    // long receiver hold-off so the design backs up onto its input
    send_gap_pct = 0;
    stall_pct = 0;
    write_block_length(7'd4);
    @(posedge clk_i);
    long_hold_go <= 1'b1;
    for (int i = 0; i < 60; i++) begin
      sample_backlog.push_back(pick_sample());
    end
    drain();

    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
